// ===== sv/sps_pkg.sv =====
// Shared types, register codes and phase tables of the stepper phase sequencer.
package sps_pkg;

  localparam int unsigned AxesDef    = 3;
  localparam int unsigned StepAxes   = 3;  // axes that carry a step count in a step item
  localparam int unsigned NumSlots   = 3;  // most results one item can cause
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ThrOffRst   = 8'd0;
  localparam logic [7:0] ThrLowRst   = 8'd20;
  localparam logic [7:0] ThrMidRst   = 8'd60;
  localparam logic [2:0] FullMaskRst = 3'd0;

  typedef enum logic [1:0] {
    OP_STEP = 2'd0,
    OP_SET  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_THR_OFF   = 2'd0,
    CFG_THR_LOW   = 2'd1,
    CFG_THR_MID   = 2'd2,
    CFG_FULL_MASK = 2'd3
  } cfg_idx_e;

  // One queued item: up to NumSlots results, sent in slot order.
  typedef struct packed {
    logic [NumSlots-1:0]      vld;
    logic [NumSlots-1:0][7:0] cmd;
    logic [NumSlots-1:0][1:0] lvl;
  } entry_t;

  localparam logic [7:0] HalfTab [4][8] = '{
    '{8'h3F, 8'h3F, 8'h1F, 8'h1F, 8'h1B, 8'h1B, 8'h3B, 8'h3B},
    '{8'h37, 8'h36, 8'h1E, 8'h16, 8'h13, 8'h12, 8'h3A, 8'h32},
    '{8'h2F, 8'h2D, 8'h1D, 8'h0D, 8'h0B, 8'h09, 8'h39, 8'h29},
    '{8'h27, 8'h2D, 8'h1C, 8'h0D, 8'h03, 8'h09, 8'h38, 8'h29}
  };

  localparam logic [7:0] FullTab [4][4] = '{
    '{8'h3F, 8'h3B, 8'h1B, 8'h1F},
    '{8'h36, 8'h32, 8'h12, 8'h16},
    '{8'h2D, 8'h29, 8'h09, 8'h0D},
    '{8'h24, 8'h20, 8'h00, 8'h04}
  };

  // Driver byte: axis address in the top bits plus the phase pattern.
  function automatic logic [7:0] phase_cmd(logic [1:0] addr, logic [2:0] ph,
                                           logic [1:0] lvl, logic full);
    logic [7:0] pat;
    pat = full ? FullTab[lvl][ph[1:0]] : HalfTab[lvl][ph];
    return {addr, 6'b0} + pat;
  endfunction

endpackage

// ===== sv/stepper_phase_sequencer_core.sv =====
// Stepper phase sequencer: one item accepted per cycle while full is low; results leave
// one per cycle while pop is high, so a step item that moves k axes gives k results (one
// to three), set and read items at most one. The output sequencer, which sends the
// results of one item in axis order, sets the sustained rate; a two-entry queue lets the
// front end keep accepting meanwhile. A result passes the queue, the current-item and the
// output registers in turn. Phase and level state change at acceptance, in item order.
module stepper_phase_sequencer_core import sps_pkg::*; #(
  parameter int unsigned AXES   = AxesDef,
  parameter int unsigned QDEPTH = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [1:0] op_i,
  input  logic [7:0] steps_x_i,
  input  logic [7:0] steps_y_i,
  input  logic [7:0] steps_z_i,
  input  logic [2:0] direction_up_i,
  input  logic [2:0] target_axis_i,
  input  logic [7:0] raw_level_i,
  input  logic       force_req_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] command_o,
  output logic [1:0] level_code_o,
  output logic       last_o
);

  logic   q_push, q_valid, q_pop;
  entry_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  sps_front #(.AXES(AXES)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .push_i    (push),
    .full_i    (full),
    .op_i,
    .steps_x_i,
    .steps_y_i,
    .steps_z_i,
    .direction_up_i,
    .target_axis_i,
    .raw_level_i,
    .force_req_i,
    .q_push_o  (q_push),
    .q_entry_o (q_wdata)
  );

  sps_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  sps_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_entry_i (q_rdata),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .command_o,
    .level_code_o,
    .last_o
  );

endmodule

// ===== sv/sps_front.sv =====
// Front end: accepts items, keeps phase and level state, forms the result bytes.
module sps_front import sps_pkg::*; #(
  parameter int unsigned AXES = AxesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i,
  input  logic         push_i,
  input  logic         full_i,
  input  logic [1:0]   op_i,
  input  logic [7:0]   steps_x_i,
  input  logic [7:0]   steps_y_i,
  input  logic [7:0]   steps_z_i,
  input  logic [2:0]   direction_up_i,
  input  logic [2:0]   target_axis_i,
  input  logic [7:0]   raw_level_i,
  input  logic         force_req_i,
  output logic         q_push_o,
  output entry_t       q_entry_o
);

  localparam int unsigned StepLim = (AXES < StepAxes) ? AXES : StepAxes;

  logic [7:0] thr_off_q, thr_low_q, thr_mid_q;
  logic [2:0] full_mask_q;
  logic [2:0] phase_q [AXES];
  logic [2:0] phase_d [AXES];
  logic [1:0] level_q [AXES];
  logic [1:0] level_d [AXES];

  logic [7:0] steps [StepAxes];
  logic [3:0] mask_ext;
  logic [1:0] lvl_new;
  logic       tgt_hit;
  logic [1:0] tgt_level;
  logic [2:0] tgt_phase;
  logic       tgt_full;
  logic       accept;
  logic [2:0] ph_new;

  assign steps[0] = steps_x_i;
  assign steps[1] = steps_y_i;
  assign steps[2] = steps_z_i;
  assign mask_ext = {1'b0, full_mask_q};
  assign accept   = push_i && !full_i;

  always_comb begin
    // Compare in the order mid, low, off regardless of threshold order.
    if (raw_level_i > thr_mid_q)      lvl_new = 2'd3;
    else if (raw_level_i > thr_low_q) lvl_new = 2'd2;
    else if (raw_level_i > thr_off_q) lvl_new = 2'd1;
    else                              lvl_new = 2'd0;
  end

  always_comb begin
    tgt_hit   = 1'b0;
    tgt_level = '0;
    tgt_phase = '0;
    tgt_full  = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (target_axis_i == 3'(a)) begin
        tgt_hit   = 1'b1;
        tgt_level = level_q[a];
        tgt_phase = phase_q[a];
        tgt_full  = mask_ext[a];
      end
    end
  end

  always_comb begin
    q_entry_o = '0;
    ph_new    = '0;
    for (int a = 0; a < AXES; a++) begin
      phase_d[a] = phase_q[a];
      level_d[a] = level_q[a];
    end
    unique case (op_e'(op_i))
      OP_STEP: begin
        for (int a = 0; a < StepLim; a++) begin
          if (steps[a] != 8'd0) begin
            ph_new = direction_up_i[a] ? phase_q[a] + steps[a][2:0]
                                       : phase_q[a] - steps[a][2:0];
            phase_d[a]       = ph_new;
            q_entry_o.vld[a] = 1'b1;
            q_entry_o.cmd[a] = phase_cmd(2'(a), ph_new, level_q[a], mask_ext[a]);
            q_entry_o.lvl[a] = level_q[a];
          end
        end
      end
      OP_SET: begin
        for (int a = 0; a < AXES; a++) begin
          if (target_axis_i == 3'(a)) level_d[a] = lvl_new;
        end
        q_entry_o.vld[0] = tgt_hit && force_req_i;
        q_entry_o.cmd[0] = phase_cmd(target_axis_i[1:0], tgt_phase, lvl_new, tgt_full);
        q_entry_o.lvl[0] = lvl_new;
      end
      OP_READ: begin
        q_entry_o.vld[0] = 1'b1;
        q_entry_o.lvl[0] = tgt_level;
      end
      OP_NONE: begin
      end
    endcase
  end

  assign q_push_o = accept && (q_entry_o.vld != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        phase_q[a] <= '0;
        level_q[a] <= '0;
      end
    end else if (accept) begin
      for (int a = 0; a < AXES; a++) begin
        phase_q[a] <= phase_d[a];
        level_q[a] <= level_d[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_off_q   <= ThrOffRst;
      thr_low_q   <= ThrLowRst;
      thr_mid_q   <= ThrMidRst;
      full_mask_q <= FullMaskRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_THR_OFF:   thr_off_q   <= cfg_data_i;
        CFG_THR_LOW:   thr_low_q   <= cfg_data_i;
        CFG_THR_MID:   thr_mid_q   <= cfg_data_i;
        CFG_FULL_MASK: full_mask_q <= cfg_data_i[2:0];
      endcase
    end
  end

endmodule

// ===== sv/sps_queue.sv =====
// Short queue of formed items between the front end and the output sequencer.
module sps_queue import sps_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // The front end only pushes when there is room.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

endmodule

// ===== sv/sps_back.sv =====
// Back end: takes queued items apart and sends their results one per cycle while pop is high.
module sps_back import sps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  entry_t     q_entry_i,
  output logic       q_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] command_o,
  output logic [1:0] level_code_o,
  output logic       last_o
);

  localparam int unsigned SlotW = $clog2(NumSlots);

  entry_t              cur_q;
  logic [NumSlots-1:0] rem_q, rem_after;
  logic [SlotW-1:0]    sel;
  logic                adv, ld;
  logic                out_vld_q;
  logic [7:0]          cmd_q;
  logic [1:0]          lvl_q;
  logic                last_q;

  always_comb begin
    sel = '0;
    for (int s = NumSlots - 1; s >= 0; s--) begin
      if (rem_q[s]) sel = SlotW'(s);
    end
  end

  assign rem_after = rem_q & ~(NumSlots'(1) << sel);
  assign adv       = (rem_q != '0) && (!out_vld_q || pop_i);
  // Fetch the next item when the current one is done or sends its last result now.
  assign ld        = q_valid_i && ((rem_q == '0) || (adv && (rem_after == '0)));
  assign q_pop_o   = ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (ld)       rem_q <= q_entry_i.vld;
      else if (adv) rem_q <= rem_after;
      if (adv)        out_vld_q <= 1'b1;
      else if (pop_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) cur_q <= q_entry_i;
    if (adv) begin
      cmd_q  <= cur_q.cmd[sel];
      lvl_q  <= cur_q.lvl[sel];
      last_q <= (rem_after == '0);
    end
  end

  assign empty_o      = !out_vld_q;
  assign command_o    = cmd_q;
  assign level_code_o = lvl_q;
  assign last_o       = last_q;

  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q) else $error("advanced result not shown");

  a_ld_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |-> ((rem_q == '0) || (rem_after == '0))) else $error("item dropped on fetch");

  a_ld_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |=> (rem_q != '0)) else $error("fetched item has no results");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the stepper phase sequencer core: directed and random traffic.
`timescale 1ns / 100ps

module tb;
  import sps_pkg::*;

  typedef struct packed {
    op_e        op;
    logic [7:0] steps_x;
    logic [7:0] steps_y;
    logic [7:0] steps_z;
    logic [2:0] dir_up;
    logic [2:0] axis;
    logic [7:0] raw;
    logic       frc;
  } motion_item_t;

  typedef struct packed {
    logic [7:0] command;
    logic [1:0] level;
    logic       last;
  } drive_cmd_t;

  localparam int unsigned NumAxes = 3;

  localparam logic [7:0] HalfPattern [4][8] = '{
    '{8'h3F, 8'h3F, 8'h1F, 8'h1F, 8'h1B, 8'h1B, 8'h3B, 8'h3B},
    '{8'h37, 8'h36, 8'h1E, 8'h16, 8'h13, 8'h12, 8'h3A, 8'h32},
    '{8'h2F, 8'h2D, 8'h1D, 8'h0D, 8'h0B, 8'h09, 8'h39, 8'h29},
    '{8'h27, 8'h2D, 8'h1C, 8'h0D, 8'h03, 8'h09, 8'h38, 8'h29}
  };

  localparam logic [7:0] FullPattern [4][4] = '{
    '{8'h3F, 8'h3B, 8'h1B, 8'h1F},
    '{8'h36, 8'h32, 8'h12, 8'h16},
    '{8'h2D, 8'h29, 8'h09, 8'h0D},
    '{8'h24, 8'h20, 8'h00, 8'h04}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       push;
  logic       full;
  logic [1:0] op_i;
  logic [7:0] steps_x_i;
  logic [7:0] steps_y_i;
  logic [7:0] steps_z_i;
  logic [2:0] direction_up_i;
  logic [2:0] target_axis_i;
  logic [7:0] raw_level_i;
  logic       force_req_i;
  logic       empty;
  logic       pop;
  logic [7:0] command_o;
  logic [1:0] level_code_o;
  logic       last_o;

  // Shadow copy of the axis state and registers
  logic [2:0] axis_phase [NumAxes];
  logic [1:0] axis_lvl   [NumAxes];
  logic [7:0] thr_off;
  logic [7:0] thr_low;
  logic [7:0] thr_mid;
  logic [2:0] full_mask;

  drive_cmd_t pending_cmds [$];

  int n_items, n_step, n_set, n_read, n_ignored, n_checked, n_cfg, n_errors;
  int burst_left;
  bit sender_steady;
  bit sink_steady;

  stepper_phase_sequencer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .steps_x_i      (steps_x_i),
    .steps_y_i      (steps_y_i),
    .steps_z_i      (steps_z_i),
    .direction_up_i (direction_up_i),
    .target_axis_i  (target_axis_i),
    .raw_level_i    (raw_level_i),
    .force_req_i    (force_req_i),
    .empty          (empty),
    .pop            (pop),
    .command_o      (command_o),
    .level_code_o   (level_code_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [1:0] quantize_level(logic [7:0] raw);
    // Compare mid first, then low, then off, whatever their order
    if (raw > thr_mid) return 2'd3;
    if (raw > thr_low) return 2'd2;
    if (raw > thr_off) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic [7:0] drive_byte(int unsigned a);
    logic [7:0] pat;
    logic [7:0] addr;
    addr = 8'(a * 64);
    if (full_mask[a]) pat = FullPattern[axis_lvl[a]][axis_phase[a][1:0]];
    else pat = HalfPattern[axis_lvl[a]][axis_phase[a]];
    return pat + addr;
  endfunction

  // Update the shadow state for one accepted item and queue the bytes it must produce
  function automatic void apply_item_to_axes(motion_item_t it);
    drive_cmd_t outs [NumAxes];
    int n;
    logic [7:0] s;
    n = 0;
    case (it.op)
      OP_STEP: begin
        n_step++;
        for (int a = 0; a < NumAxes; a++) begin
          case (a)
            0: s = it.steps_x;
            1: s = it.steps_y;
            default: s = it.steps_z;
          endcase
          if (s != 8'd0) begin
            if (it.dir_up[a]) axis_phase[a] = axis_phase[a] + s[2:0];
            else axis_phase[a] = axis_phase[a] - s[2:0];
            outs[n] = '{command: drive_byte(a), level: axis_lvl[a], last: 1'b0};
            n++;
          end
        end
      end
      OP_SET: begin
        n_set++;
        if (it.axis < NumAxes) begin
          axis_lvl[it.axis] = quantize_level(it.raw);
          if (it.frc) begin
            outs[0] = '{command: drive_byte(it.axis), level: axis_lvl[it.axis], last: 1'b0};
            n = 1;
          end
        end
      end
      OP_READ: begin
        n_read++;
        outs[0] = '{command: 8'd0,
                    level: (it.axis < NumAxes) ? axis_lvl[it.axis] : 2'd0,
                    last: 1'b0};
        n = 1;
      end
      default: n_ignored++;
    endcase
    for (int i = 0; i < n; i++) begin
      outs[i].last = (i == n - 1);
      pending_cmds.push_back(outs[i]);
    end
  endfunction

  function automatic motion_item_t make_item(op_e op, logic [7:0] sx, logic [7:0] sy,
                                             logic [7:0] sz, logic [2:0] dir,
                                             logic [2:0] axis, logic [7:0] raw, logic frc);
    motion_item_t it;
    it.op      = op;
    it.steps_x = sx;
    it.steps_y = sy;
    it.steps_z = sz;
    it.dir_up  = dir;
    it.axis    = axis;
    it.raw     = raw;
    it.frc     = frc;
    return it;
  endfunction

  function automatic logic [7:0] random_steps();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'd0;
    if (r < 7) return 8'($urandom_range(1, 9));
    if (r < 9) return 8'($urandom_range(0, 255));
    return 8'd255;
  endfunction

  // Favor values on and just above the thresholds
  function automatic logic [7:0] random_raw();
    int unsigned r;
    logic [7:0] t;
    r = $urandom_range(0, 5);
    case ($urandom_range(0, 2))
      0: t = thr_off;
      1: t = thr_low;
      default: t = thr_mid;
    endcase
    if (r < 2) return t;
    if (r < 4) return t + 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic motion_item_t random_item();
    motion_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) it.op = OP_STEP;
    else if (pick < 78) it.op = OP_SET;
    else if (pick < 94) it.op = OP_READ;
    else it.op = OP_NONE;
    it.steps_x = random_steps();
    it.steps_y = random_steps();
    it.steps_z = random_steps();
    it.dir_up  = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) < 8) it.axis = 3'($urandom_range(0, 2));
    else it.axis = 3'($urandom_range(3, 7));
    it.raw = random_raw();
    it.frc = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  // Push one item, idling between bursts unless the sender is steady; push stays high across a burst
  task automatic send_item(input motion_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (!sender_steady) begin
        gap = $urandom_range(1, 6);
        @(negedge clk_i);
        push = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    op_i           = it.op;
    steps_x_i      = it.steps_x;
    steps_y_i      = it.steps_y;
    steps_z_i      = it.steps_z;
    direction_up_i = it.dir_up;
    target_axis_i  = it.axis;
    raw_level_i    = it.raw;
    force_req_i    = it.frc;
    push           = 1'b1;
    do @(posedge clk_i); while (full);
    apply_item_to_axes(it);
    n_items++;
  endtask

  // Drop push, wait for every queued byte, then let silent items retire
  task automatic drain_and_settle();
    @(negedge clk_i);
    push = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_THR_OFF:   thr_off   = val;
      CFG_THR_LOW:   thr_low   = val;
      CFG_THR_MID:   thr_mid   = val;
      CFG_FULL_MASK: full_mask = val[2:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(input logic [7:0] off, input logic [7:0] low,
                           input logic [7:0] mid, input logic [7:0] mask);
    drain_and_settle();
    write_register(CFG_THR_OFF, off);
    write_register(CFG_THR_LOW, low);
    write_register(CFG_THR_MID, mid);
    write_register(CFG_FULL_MASK, mask);
  endtask

  // Levels are all off after reset; out-of-range reads give off too; an empty step and a reserved op give nothing
  task automatic test_idle_reads();
    for (int a = 0; a < 8; a++) send_item(make_item(OP_READ, 0, 0, 0, 0, 3'(a), 0, 0));
    send_item(make_item(OP_STEP, 0, 0, 0, 3'd7, 0, 8'hFF, 1));
    send_item(make_item(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 3'd7, 3'd1, 8'hFF, 1));
  endtask

  task automatic test_step_extremes();
    send_item(make_item(OP_STEP, 8'd255, 8'd255, 8'd255, 3'd7, 0, 0, 0));
    send_item(make_item(OP_STEP, 8'd255, 8'd255, 8'd255, 3'd0, 0, 0, 0));
    send_item(make_item(OP_STEP, 8'd1, 8'd0, 8'd0, 3'd0, 0, 0, 0));
    send_item(make_item(OP_STEP, 8'd0, 8'd1, 8'd0, 3'd2, 0, 0, 0));
    send_item(make_item(OP_STEP, 8'd0, 8'd0, 8'd1, 3'd5, 0, 0, 0));
  endtask

  // Hit each reset threshold and the value above the low and mid ones, with and without force
  task automatic test_level_quantization();
    send_item(make_item(OP_SET, 0, 0, 0, 0, 3'd0, 8'd0, 1'b1));
    send_item(make_item(OP_SET, 0, 0, 0, 0, 3'd1, 8'd20, 1'b1));
    send_item(make_item(OP_SET, 0, 0, 0, 0, 3'd2, 8'd21, 1'b1));
    send_item(make_item(OP_SET, 0, 0, 0, 0, 3'd0, 8'd60, 1'b1));
    send_item(make_item(OP_SET, 0, 0, 0, 0, 3'd1, 8'd61, 1'b0));
    send_item(make_item(OP_SET, 0, 0, 0, 0, 3'd2, 8'd255, 1'b1));
    send_item(make_item(OP_SET, 0, 0, 0, 0, 3'd3, 8'd255, 1'b1));
    send_item(make_item(OP_SET, 0, 0, 0, 0, 3'd7, 8'd255, 1'b1));
    for (int a = 0; a < NumAxes; a++) send_item(make_item(OP_READ, 0, 0, 0, 0, 3'(a), 0, 0));
  endtask

  // Several register settings, extremes and non-ascending thresholds among them
  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(8'd0, 8'd20, 8'd60, 8'd0);
        1: configure(8'd0, 8'd0, 8'd0, 8'd7);
        2: configure(8'd255, 8'd255, 8'd255, 8'd0);
        3: configure(8'd200, 8'd100, 8'd50, 8'd5);
        4: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: configure(8'd10, 8'd128, 8'd200, 8'd2);
      endcase
      sender_steady = (p % 3 == 1);
      sink_steady   = (p % 3 == 2);
      repeat (25) send_item(random_item());
    end
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
  endtask

  initial begin : sink_ctrl
    int n_on;
    int n_off;
    pop = 1'b0;
    forever begin
      n_on = $urandom_range(1, 12);
      repeat (n_on) @(negedge clk_i) pop = 1'b1;
      if (!sink_steady) begin
        n_off = $urandom_range(1, 8);
        repeat (n_off) @(negedge clk_i) pop = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : cmd_check
    drive_cmd_t due;
    if (rst_ni && pop && !empty) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected result: command %0h level_code %0d last %0b",
               command_o, level_code_o, last_o);
        n_errors++;
      end else begin
        due = pending_cmds.pop_front();
        n_checked++;
        if (command_o !== due.command) begin
          $error("command: expected %0h, got %0h", due.command, command_o);
          n_errors++;
        end
        if (level_code_o !== due.level) begin
          $error("level_code: expected %0d, got %0d", due.level, level_code_o);
          n_errors++;
        end
        if (last_o !== due.last) begin
          $error("last: expected %0b, got %0b", due.last, last_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    push           = 1'b0;
    op_i           = OP_STEP;
    steps_x_i      = '0;
    steps_y_i      = '0;
    steps_z_i      = '0;
    direction_up_i = '0;
    target_axis_i  = '0;
    raw_level_i    = '0;
    force_req_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_THR_OFF;
    cfg_data_i     = '0;
    thr_off        = ThrOffRst;
    thr_low        = ThrLowRst;
    thr_mid        = ThrMidRst;
    full_mask      = FullMaskRst;
    for (int a = 0; a < NumAxes; a++) begin
      axis_phase[a] = '0;
      axis_lvl[a]   = '0;
    end
    n_items = 0; n_step = 0; n_set = 0; n_read = 0; n_ignored = 0;
    n_checked = 0; n_cfg = 0; n_errors = 0;
    burst_left    = 0;
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_reads();
    test_step_extremes();
    test_level_quantization();
    test_random_traffic();
    drain_and_settle();

    $display("Sent %0d items: %0d step, %0d set-level, %0d read, %0d reserved op",
             n_items, n_step, n_set, n_read, n_ignored);
    $display("Checked %0d command bytes over %0d register writes", n_checked, n_cfg);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
